/* rtl/fotr_pkg.sv */
package fotr_pkg;

   localparam int VALUE_W    = 32;
   localparam int IDX_W      = 2;
   localparam int FUNC_W     = 2;
   localparam int THR_W      = 31;
   localparam int NUM_ROWS   = 4;
   localparam int ROW_SEL_W  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_TENSOR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_ROTATION = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY         = 2'd2;

   // Register index, taken from address bit 2.
   localparam logic CSR_IDX_FLUSH_THRESHOLD = 1'b0;

   localparam logic [VALUE_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] S32_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROWS,
      ST_SETTLE,
      ST_TERMS,
      ST_DRAIN,
      ST_CLAMP,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic write_tensor;
      logic write_rot;
      logic capture;
      logic row_step;
      logic term_step;
      logic clamp;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic query_ok;
      logic row_last;
      logic term_last;
      logic pipe_busy;
   } dpath_status_type;

endpackage

/* rtl/fotr_ctrl.sv */
module fotr_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [fotr_pkg::FUNC_W-1:0]     req_func,
   output logic                            req_ready,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   input  fotr_pkg::dpath_status_type      status,
   output fotr_pkg::ctrl_cmd_type          cmd
);

   fotr_pkg::ctrl_state_type state_ff;
   fotr_pkg::ctrl_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fotr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fotr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  fotr_pkg::FUNC_LOAD_TENSOR: begin
                     cmd.write_tensor = 1'b1;
                  end
                  fotr_pkg::FUNC_LOAD_ROTATION: begin
                     cmd.write_rot = 1'b1;
                  end
                  fotr_pkg::FUNC_QUERY: begin
                     cmd.capture = 1'b1;
                     state_in    = status.query_ok ? fotr_pkg::ST_ROWS : fotr_pkg::ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         fotr_pkg::ST_ROWS: begin
            cmd.row_step = 1'b1;
            if (status.row_last) begin
               state_in = fotr_pkg::ST_SETTLE;
            end
         end
         fotr_pkg::ST_SETTLE: begin
            state_in = fotr_pkg::ST_TERMS;
         end
         fotr_pkg::ST_TERMS: begin
            cmd.term_step = 1'b1;
            if (status.term_last) begin
               state_in = fotr_pkg::ST_DRAIN;
            end
         end
         fotr_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = fotr_pkg::ST_CLAMP;
            end
         end
         fotr_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = fotr_pkg::ST_EMIT;
         end
         fotr_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = fotr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fotr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/fotr_dpath.sv */
module fotr_dpath #(
   parameter int DIM       = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fotr_pkg::ctrl_cmd_type                cmd,
   output fotr_pkg::dpath_status_type            status,
   input  logic [fotr_pkg::IDX_W-1:0]            first_index,
   input  logic [fotr_pkg::IDX_W-1:0]            second_index,
   input  logic [fotr_pkg::IDX_W-1:0]            third_index,
   input  logic [fotr_pkg::IDX_W-1:0]            fourth_index,
   input  logic signed [fotr_pkg::VALUE_W-1:0]   element_value,
   input  logic [fotr_pkg::THR_W-1:0]            flush_threshold,
   output logic signed [fotr_pkg::VALUE_W-1:0]   rotated_value,
   output logic                                  saturated
);

   localparam int VW      = fotr_pkg::VALUE_W;
   localparam int NR      = fotr_pkg::NUM_ROWS;
   localparam int TSIZE   = DIM * DIM * DIM * DIM;
   localparam int RSIZE   = DIM * DIM;
   localparam int TADDR_W = $clog2(TSIZE);
   localparam int RADDR_W = $clog2(RSIZE);
   localparam int DIGIT_W = $clog2(DIM);
   localparam int ACC_W   = VW + $clog2(TSIZE) + 1;

   localparam logic [DIGIT_W-1:0] DIGIT_LAST = DIGIT_W'(DIM - 1);
   localparam logic [fotr_pkg::IDX_W-1:0] IDX_LIMIT = fotr_pkg::IDX_W'(DIM);

   // Fixed-point multiply: floor shift by the fraction width, clamp to 32 bits.
   // Result is {clamped, value}.
   function automatic logic [VW:0] fmul(input logic signed [VW-1:0] a,
                                        input logic signed [VW-1:0] b);
      logic signed [2*VW-1:0] prod;
      logic signed [2*VW-1:0] sh;
      logic [VW:0]            res;
      prod = (2*VW)'(a) * (2*VW)'(b);
      sh   = prod >>> FRAC_BITS;
      if ((sh[2*VW-1:VW-1] == '0) || (sh[2*VW-1:VW-1] == '1)) begin
         res = {1'b0, sh[VW-1:0]};
      end else if (sh[2*VW-1]) begin
         res = {1'b1, fotr_pkg::S32_MIN};
      end else begin
         res = {1'b1, fotr_pkg::S32_MAX};
      end
      return res;
   endfunction

   function automatic logic [TADDR_W-1:0] taddr(input logic [DIGIT_W-1:0] i,
                                                input logic [DIGIT_W-1:0] j,
                                                input logic [DIGIT_W-1:0] k,
                                                input logic [DIGIT_W-1:0] l);
      logic [TADDR_W-1:0] d;
      d = TADDR_W'(DIM);
      return ((TADDR_W'(i) * d + TADDR_W'(j)) * d + TADDR_W'(k)) * d + TADDR_W'(l);
   endfunction

   // Request index checks.
   logic idx_ok_a, idx_ok_b, idx_ok_c, idx_ok_d;
   logic query_ok;
   logic rot_ok;
   logic [DIGIT_W-1:0] dig_a, dig_b, dig_c, dig_d;

   assign idx_ok_a = first_index  < IDX_LIMIT;
   assign idx_ok_b = second_index < IDX_LIMIT;
   assign idx_ok_c = third_index  < IDX_LIMIT;
   assign idx_ok_d = fourth_index < IDX_LIMIT;
   assign query_ok = idx_ok_a && idx_ok_b && idx_ok_c && idx_ok_d;
   assign rot_ok   = idx_ok_a && idx_ok_b;
   assign dig_a    = first_index[DIGIT_W-1:0];
   assign dig_b    = second_index[DIGIT_W-1:0];
   assign dig_c    = third_index[DIGIT_W-1:0];
   assign dig_d    = fourth_index[DIGIT_W-1:0];

   // Stores.
   logic signed [VW-1:0] tensor_mem [TSIZE];
   logic signed [VW-1:0] rot_mem [RSIZE];
   logic signed [VW-1:0] t_rd_ff;
   logic signed [VW-1:0] rot_rd_ff;
   logic [RADDR_W-1:0]   row_addr;

   // Query state and sequencing counters.
   logic [DIGIT_W-1:0]             qidx_ff [NR];
   logic                           bad_ff;
   logic [fotr_pkg::ROW_SEL_W-1:0] row_sel_ff, row_sel_in;
   logic [DIGIT_W-1:0]             col_ff, col_in;
   logic [DIGIT_W-1:0]             dig_ff [NR];
   logic [DIGIT_W-1:0]             dig_in [NR];

   always_ff @(posedge clock) begin
      if (cmd.write_tensor && query_ok) begin
         tensor_mem[taddr(dig_a, dig_b, dig_c, dig_d)] <= element_value;
      end
   end

   always_ff @(posedge clock) begin
      t_rd_ff <= tensor_mem[taddr(dig_ff[0], dig_ff[1], dig_ff[2], dig_ff[3])];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_rot && rot_ok) begin
         rot_mem[RADDR_W'(dig_a) * RADDR_W'(DIM) + RADDR_W'(dig_b)] <= element_value;
      end
   end

   assign row_addr = RADDR_W'(qidx_ff[row_sel_ff]) * RADDR_W'(DIM) + RADDR_W'(col_ff);

   always_ff @(posedge clock) begin
      rot_rd_ff <= rot_mem[row_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qidx_ff[0] <= dig_a;
         qidx_ff[1] <= dig_b;
         qidx_ff[2] <= dig_c;
         qidx_ff[3] <= dig_d;
         bad_ff     <= !query_ok;
      end
   end

   always_comb begin
      row_sel_in = row_sel_ff;
      col_in     = col_ff;
      if (cmd.capture) begin
         row_sel_in = '0;
         col_in     = '0;
      end else if (cmd.row_step) begin
         if (col_ff == DIGIT_LAST) begin
            col_in     = '0;
            row_sel_in = row_sel_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int d = 0; d < NR; d++) begin
         dig_in[d] = dig_ff[d];
      end
      if (cmd.capture) begin
         for (int d = 0; d < NR; d++) begin
            dig_in[d] = '0;
         end
      end else if (cmd.term_step) begin
         // The last digit runs fastest.
         for (int d = NR - 1; d >= 0; d--) begin
            if (carry) begin
               if (dig_ff[d] == DIGIT_LAST) begin
                  dig_in[d] = '0;
               end else begin
                  dig_in[d] = dig_ff[d] + 1'b1;
                  carry     = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      row_sel_ff <= row_sel_in;
      col_ff     <= col_in;
      for (int d = 0; d < NR; d++) begin
         dig_ff[d] <= dig_in[d];
      end
   end

   // Rotation rows of the query, filled from the rotation store.
   logic signed [VW-1:0]           row_ff [NR][DIM];
   logic                           row_wr_v_ff;
   logic [fotr_pkg::ROW_SEL_W-1:0] row_wr_sel_ff;
   logic [DIGIT_W-1:0]             row_wr_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_wr_v_ff <= 1'b0;
      end else begin
         row_wr_v_ff <= cmd.row_step;
      end
   end

   always_ff @(posedge clock) begin
      row_wr_sel_ff <= row_sel_ff;
      row_wr_col_ff <= col_ff;
      if (row_wr_v_ff) begin
         row_ff[row_wr_sel_ff][row_wr_col_ff] <= rot_rd_ff;
      end
   end

   // Term pipeline: factor select, then four multiplies, then accumulate.
   logic [4:0]            pipe_v_ff;
   logic signed [VW-1:0]  fac_ff [NR];
   logic signed [VW-1:0]  p1_ff, c_b_ff, d_b_ff, t_b_ff;
   logic signed [VW-1:0]  p2_ff, d_c_ff, t_c_ff;
   logic signed [VW-1:0]  p3_ff, t_d_ff;
   logic signed [VW-1:0]  p4_ff;
   logic                  sat_b_ff, sat_c_ff, sat_d_ff, sat_e_ff;
   logic [VW:0]           mul_b, mul_c, mul_d, mul_e;
   logic [ACC_W-1:0]      acc_ff;
   logic                  acc_sat_ff;

   assign mul_b = fmul(fac_ff[0], fac_ff[1]);
   assign mul_c = fmul(p1_ff, c_b_ff);
   assign mul_d = fmul(p2_ff, d_c_ff);
   assign mul_e = fmul(p3_ff, t_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else begin
         pipe_v_ff <= {pipe_v_ff[3:0], cmd.term_step};
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NR; r++) begin
         fac_ff[r] <= row_ff[r][dig_ff[r]];
      end
      p1_ff    <= mul_b[VW-1:0];
      sat_b_ff <= mul_b[VW];
      c_b_ff   <= fac_ff[2];
      d_b_ff   <= fac_ff[3];
      t_b_ff   <= t_rd_ff;
      p2_ff    <= mul_c[VW-1:0];
      sat_c_ff <= sat_b_ff | mul_c[VW];
      d_c_ff   <= d_b_ff;
      t_c_ff   <= t_b_ff;
      p3_ff    <= mul_d[VW-1:0];
      sat_d_ff <= sat_c_ff | mul_d[VW];
      t_d_ff   <= t_c_ff;
      p4_ff    <= mul_e[VW-1:0];
      sat_e_ff <= sat_d_ff | mul_e[VW];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_ff     <= '0;
         acc_sat_ff <= 1'b0;
      end else if (pipe_v_ff[4]) begin
         acc_ff     <= acc_ff + {{(ACC_W - VW){p4_ff[VW-1]}}, p4_ff};
         acc_sat_ff <= acc_sat_ff | sat_e_ff;
      end
   end

   // Final clamp, then flush on magnitude.
   logic [VW-1:0] clamped_ff;
   logic          clamp_sat_ff;
   logic          acc_fits;
   logic [VW:0]   mag;
   logic          flush;
   logic [VW-1:0] rotated_value_ff;
   logic          saturated_ff;

   assign acc_fits = (acc_ff[ACC_W-1:VW-1] == '0) || (acc_ff[ACC_W-1:VW-1] == '1);

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         clamp_sat_ff <= acc_sat_ff | !acc_fits;
         if (acc_fits) begin
            clamped_ff <= acc_ff[VW-1:0];
         end else if (acc_ff[ACC_W-1]) begin
            clamped_ff <= fotr_pkg::S32_MIN;
         end else begin
            clamped_ff <= fotr_pkg::S32_MAX;
         end
      end
   end

   assign mag   = clamped_ff[VW-1] ? ((VW + 1)'(0) - {1'b1, clamped_ff}) : {1'b0, clamped_ff};
   assign flush = mag <= {2'b00, flush_threshold};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rotated_value_ff <= (bad_ff || flush) ? '0 : clamped_ff;
         saturated_ff     <= bad_ff ? 1'b0 : clamp_sat_ff;
      end
   end

   assign rotated_value = rotated_value_ff;
   assign saturated     = saturated_ff;

   assign status.query_ok  = query_ok;
   assign status.row_last  = (row_sel_ff == fotr_pkg::ROW_SEL_W'(NR - 1)) && (col_ff == DIGIT_LAST);
   assign status.term_last = (dig_ff[0] == DIGIT_LAST) && (dig_ff[1] == DIGIT_LAST) &&
                             (dig_ff[2] == DIGIT_LAST) && (dig_ff[3] == DIGIT_LAST);
   assign status.pipe_busy = |pipe_v_ff;

endmodule

/* rtl/fourth_order_tensor_rotation.sv */
// Channel    Direction  Handshake              Payload
// req        in         req_valid/req_ready    func, four indices, element_value
// rsp        out        rsp_valid/rsp_ready    rotated_value, saturated
// csr        in/out     psel/penable, pready   flush_threshold at byte address 0
//
// A load transaction is written to its store in the cycle it is accepted. For a query in range,
// the four needed rotation rows are read from the rotation store one word a cycle, then
// one term a cycle goes through the four-multiplier chain, fed by the single read port of
// the tensor store. An out-of-range query skips both steps and answers with zero.
// Reset is synchronous and active high; it clears control state and the threshold. The
// stores hold no reset value. A finished result waits in the output register, and new
// transactions are taken while it waits; only the next result stalls on rsp_ready.
module fourth_order_tensor_rotation #(
   parameter int DIM       = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [fotr_pkg::FUNC_W-1:0]           req_func,
   input  logic [fotr_pkg::IDX_W-1:0]            req_first_index,
   input  logic [fotr_pkg::IDX_W-1:0]            req_second_index,
   input  logic [fotr_pkg::IDX_W-1:0]            req_third_index,
   input  logic [fotr_pkg::IDX_W-1:0]            req_fourth_index,
   input  logic signed [fotr_pkg::VALUE_W-1:0]   req_element_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fotr_pkg::VALUE_W-1:0]   rsp_rotated_value,
   output logic                                  rsp_saturated,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fotr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [fotr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [fotr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   // Configuration register. Only address bit 2 selects a register; the low
   // byte-offset bits are ignored, and the upper word lies beyond the map.
   logic [fotr_pkg::THR_W-1:0] flush_threshold_ff;
   logic [fotr_pkg::THR_W-1:0] flush_threshold_in;
   logic                       csr_sel_thr;

   assign csr_pready  = 1'b1;
   assign csr_sel_thr = csr_paddr[2] == fotr_pkg::CSR_IDX_FLUSH_THRESHOLD;

   always_comb begin
      flush_threshold_in = flush_threshold_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_thr) begin
         flush_threshold_in = csr_pwdata[fotr_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_threshold_ff <= '0;
      end else begin
         flush_threshold_ff <= flush_threshold_in;
      end
   end

   assign csr_prdata = csr_sel_thr ? {1'b0, flush_threshold_ff} : '0;

   // The controller sequences each query; the datapath holds the stores,
   // the term pipeline and the output register.
   fotr_pkg::ctrl_cmd_type     ctrl_cmd;
   fotr_pkg::dpath_status_type dpath_status;

   fotr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (dpath_status),
      .cmd       (ctrl_cmd)
   );

   fotr_dpath #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dpath_status),
      .first_index     (req_first_index),
      .second_index    (req_second_index),
      .third_index     (req_third_index),
      .fourth_index    (req_fourth_index),
      .element_value   (req_element_value),
      .flush_threshold (flush_threshold_ff),
      .rotated_value   (rsp_rotated_value),
      .saturated       (rsp_saturated)
   );

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while a result waits");

   // The controller issues at most one command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctrl_cmd))
      else $error("more than one datapath command in a cycle");

   // Store writes and query captures happen only on an accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.write_tensor || ctrl_cmd.write_rot || ctrl_cmd.capture) |->
         (req_valid && req_ready))
      else $error("store write or capture without an accepted transaction");

   // While rows are fetched or terms are issued or still in the pipeline, no new transaction is taken.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.term_step || ctrl_cmd.row_step || dpath_status.pipe_busy) |-> !req_ready)
      else $error("input taken while a query is in flight");

endmodule
